@@ hdl/hvc_pkg.sv @@
package hvc_pkg;

  // Field and register widths.
  localparam int unsigned SampleW   = 16;
  localparam int unsigned InvSpanW  = 32;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned TW        = 17;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 32;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgValueMin    = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgInverseSpan = 8'd1;
  localparam logic [CfgIndexW-1:0] CfgRampSelect  = 8'd2;
  localparam logic [CfgIndexW-1:0] CfgOpacity     = 8'd3;

  // Register reset values.
  localparam logic [SampleW-1:0]  ValueMinReset    = 16'd0;
  localparam logic [InvSpanW-1:0] InverseSpanReset = 32'd65536;
  localparam logic [ChanW-1:0]    OpacityReset     = 8'd255;

  // 1.0 in Q16.16.
  localparam logic [TW-1:0] OneQ16 = 17'd65536;

  // Ramp selection codes.
  typedef enum logic {
    RAMP_SEQUENTIAL = 1'b0,
    RAMP_DIVERGING  = 1'b1
  } ramp_e;

  // One colour stop, packed as red, green, blue.
  typedef logic [3*ChanW-1:0] rgb_t;

  localparam rgb_t SeqStops [5] = '{
    24'h0D1428, 24'h2F508C, 24'h2E96A0, 24'h78C86E, 24'hE6C85A
  };
  localparam rgb_t DivStops [3] = '{
    24'h5A8CD2, 24'h161E2E, 24'hE06A6A
  };

  // Colour of one stop of the selected ramp.
  function automatic rgb_t stop_rgb(input ramp_e sel, input logic [2:0] idx);
    rgb_t res;
    res = '0;
    if (sel == RAMP_DIVERGING) begin
      if (idx < 3'd3) begin
        res = DivStops[idx[1:0]];
      end
    end else begin
      if (idx < 3'd5) begin
        res = SeqStops[idx];
      end
    end
    return res;
  endfunction

endpackage

@@ hdl/heatmap_value_to_colour_top.sv @@
// Heat-map colour mapper: each signed 16-bit sample is normalised against
// value_min and inverse_span (unsigned Q16.16), clamped to [0, 1], looked up on
// a five-stop sequential or three-stop diverging colour ramp with linear
// interpolation, and premultiplied by opacity; alpha carries the opacity.
// The block takes one sample per clock unless a stalled output has filled its
// stages. Its colour passes through five register stages: subtract, 16x32
// scale and clamp, ramp interpolation, opacity multiply, and divide by 255.
// Each stage holds its item independently, so empty stages fill while the
// output is stalled. Configuration writes are always accepted and must be
// made while no transaction is in flight.
module heatmap_value_to_colour_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [hvc_pkg::SampleW-1:0]  sample_value_i,
  // Colour output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [hvc_pkg::ChanW-1:0]           red_o,
  output logic [hvc_pkg::ChanW-1:0]           green_o,
  output logic [hvc_pkg::ChanW-1:0]           blue_o,
  output logic [hvc_pkg::ChanW-1:0]           alpha_o,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hvc_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [hvc_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  localparam int unsigned NumStages = 5;

  logic signed [hvc_pkg::SampleW-1:0] value_min_q;
  logic [hvc_pkg::InvSpanW-1:0]       inverse_span_q;
  hvc_pkg::ramp_e                     ramp_select_q;
  logic [hvc_pkg::ChanW-1:0]          opacity_q;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] en;
  logic [hvc_pkg::TW-1:0] t;
  hvc_pkg::rgb_t          ramp_rgb, out_rgb;

  // Configuration registers; a write to an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_min_q    <= hvc_pkg::ValueMinReset;
      inverse_span_q <= hvc_pkg::InverseSpanReset;
      ramp_select_q  <= hvc_pkg::RAMP_SEQUENTIAL;
      opacity_q      <= hvc_pkg::OpacityReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hvc_pkg::CfgValueMin:    value_min_q    <= cfg_wdata_i[hvc_pkg::SampleW-1:0];
        hvc_pkg::CfgInverseSpan: inverse_span_q <= cfg_wdata_i[hvc_pkg::InvSpanW-1:0];
        hvc_pkg::CfgRampSelect:  ramp_select_q  <= hvc_pkg::ramp_e'(cfg_wdata_i[0]);
        hvc_pkg::CfgOpacity:     opacity_q      <= cfg_wdata_i[hvc_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or the stage after it moves.
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NumStages-1];

  // Datapath stages.
  hvc_norm u_norm (
    .clk_i          (clk_i),
    .en_i           (en[1:0]),
    .sample_value_i (sample_value_i),
    .value_min_i    (value_min_q),
    .inverse_span_i (inverse_span_q),
    .t_o            (t)
  );

  hvc_ramp u_ramp (
    .clk_i         (clk_i),
    .en_i          (en[2]),
    .ramp_select_i (ramp_select_q),
    .t_i           (t),
    .rgb_o         (ramp_rgb)
  );

  hvc_premul u_premul (
    .clk_i     (clk_i),
    .en_i      (en[4:3]),
    .rgb_i     (ramp_rgb),
    .opacity_i (opacity_q),
    .rgb_o     (out_rgb)
  );

  assign red_o   = out_rgb[3*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW];
  assign green_o = out_rgb[2*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW];
  assign blue_o  = out_rgb[hvc_pkg::ChanW-1 -: hvc_pkg::ChanW];
  assign alpha_o = opacity_q;

endmodule

@@ hdl/hvc_norm.sv @@
module hvc_norm (
  input  logic                                clk_i,
  input  logic [1:0]                          en_i,
  input  logic signed [hvc_pkg::SampleW-1:0]  sample_value_i,
  input  logic signed [hvc_pkg::SampleW-1:0]  value_min_i,
  input  logic [hvc_pkg::InvSpanW-1:0]        inverse_span_i,
  output logic [hvc_pkg::TW-1:0]              t_o
);

  logic [hvc_pkg::SampleW:0]                        diff_d, diff_q;
  logic                                             diff_pos;
  logic [hvc_pkg::SampleW+hvc_pkg::InvSpanW-1:0]    prod;
  logic [hvc_pkg::TW-1:0]                           t_d, t_q;

  // First stage: distance of the sample above the minimum, 17-bit signed.
  assign diff_d = {sample_value_i[hvc_pkg::SampleW-1], sample_value_i}
                - {value_min_i[hvc_pkg::SampleW-1], value_min_i};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      diff_q <= diff_d;
    end
  end

  // Second stage: scale by the reciprocal span and clamp to [0, 1].
  assign diff_pos = !diff_q[hvc_pkg::SampleW] && (diff_q != '0);
  assign prod = (hvc_pkg::SampleW+hvc_pkg::InvSpanW)'(diff_q[hvc_pkg::SampleW-1:0])
              * (hvc_pkg::SampleW+hvc_pkg::InvSpanW)'(inverse_span_i);

  always_comb begin
    if (!diff_pos) begin
      t_d = '0;
    end else if (prod > (hvc_pkg::SampleW+hvc_pkg::InvSpanW)'(hvc_pkg::OneQ16)) begin
      t_d = hvc_pkg::OneQ16;
    end else begin
      t_d = prod[hvc_pkg::TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

@@ hdl/hvc_ramp.sv @@
module hvc_ramp (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  hvc_pkg::ramp_e                ramp_select_i,
  input  logic [hvc_pkg::TW-1:0]        t_i,
  output hvc_pkg::rgb_t                 rgb_o
);

  logic [hvc_pkg::TW-1:0] t_m1;
  logic [1:0]             seg;
  logic [hvc_pkg::TW-1:0] seg_start;
  logic [hvc_pkg::TW-1:0] u;
  hvc_pkg::rgb_t          lo_rgb, hi_rgb;
  hvc_pkg::rgb_t          rgb_d, rgb_q;

  // Segment choice: a t on an interior stop belongs to the lower segment.
  assign t_m1 = t_i - hvc_pkg::TW'(1);

  always_comb begin
    if (t_i == '0) begin
      seg = 2'd0;
    end else if (ramp_select_i == hvc_pkg::RAMP_DIVERGING) begin
      seg = {1'b0, t_m1[15]};
    end else begin
      seg = t_m1[15:14];
    end
  end

  always_comb begin
    if (ramp_select_i == hvc_pkg::RAMP_DIVERGING) begin
      seg_start = {1'b0, seg[0], 15'd0};
    end else begin
      seg_start = {1'b0, seg, 14'd0};
    end
  end

  assign u      = t_i - seg_start;
  assign lo_rgb = hvc_pkg::stop_rgb(ramp_select_i, {1'b0, seg});
  assign hi_rgb = hvc_pkg::stop_rgb(ramp_select_i, 3'({1'b0, seg}) + 3'd1);

  // Linear mix per channel with round-half-up; the segment width is a power of two.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [hvc_pkg::ChanW-1:0] a, b;
    logic signed [8:0]         step;
    logic signed [26:0]        slope;
    logic signed [27:0]        base, half, num;

    assign a     = lo_rgb[(3-c)*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW];
    assign b     = hi_rgb[(3-c)*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW];
    assign step  = $signed({1'b0, b}) - $signed({1'b0, a});
    assign slope = step * $signed({1'b0, u});

    always_comb begin
      if (ramp_select_i == hvc_pkg::RAMP_DIVERGING) begin
        base = $signed({5'd0, a, 15'd0});
        half = $signed(28'd16384);
      end else begin
        base = $signed({6'd0, a, 14'd0});
        half = $signed(28'd8192);
      end
    end

    assign num = base + $signed({slope[26], slope}) + half;

    always_comb begin
      if (ramp_select_i == hvc_pkg::RAMP_DIVERGING) begin
        rgb_d[(3-c)*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW] = num[22:15];
      end else begin
        rgb_d[(3-c)*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW] = num[21:14];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

@@ hdl/hvc_premul.sv @@
module hvc_premul (
  input  logic                          clk_i,
  input  logic [1:0]                    en_i,
  input  hvc_pkg::rgb_t                 rgb_i,
  input  logic [hvc_pkg::ChanW-1:0]     opacity_i,
  output hvc_pkg::rgb_t                 rgb_o
);

  hvc_pkg::rgb_t rgb_d, rgb_q;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [15:0] scaled_d, scaled_q;
    logic [15:0] quot_sum;

    // First stage: channel times opacity plus the rounding offset.
    assign scaled_d = 16'(rgb_i[(3-c)*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW])
                    * 16'(opacity_i) + 16'd127;

    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        scaled_q <= scaled_d;
      end
    end

    // Second stage: divide by 255 as (x + x/256 + 1) / 256, exact for x up to 65152, the largest scaled value.
    assign quot_sum = scaled_q + {8'd0, scaled_q[15:8]} + 16'd1;
    assign rgb_d[(3-c)*hvc_pkg::ChanW-1 -: hvc_pkg::ChanW] = quot_sum[15:8];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule
